// ===== hdl/cba_pkg.sv =====
// Shared types and constants for the contiguous block allocator.
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;

	localparam int WORD_W = 32;
	localparam int WORD_LG = 5;
	localparam int HINT_W = 12;
	localparam int LEN_W = 7;
	localparam int RUN_W = LEN_W + 1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_MARK  = 5'b01000,
		S_RESP  = 5'b10000
	} cba_state_t;

endpackage
`default_nettype wire

// ===== hdl/cba_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module cba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/contiguous_block_allocator_top.sv =====
// Bitmap first-fit contiguous block allocator, top level.
//
//  channel | direction | handshake            | payload
//  request | in        | in_valid / in_ready  | start_hint, run_length
//  result  | out       | out_valid / out_ready| found, first_block
//
// The free map sits in a RAM of 32-bit rows, BLOCK_COUNT/32 deep, one row read a cycle.
// A request scans rows from the hint row towards the last row until the run is found,
// then marks the rows covered by the run, then loads the result register.
// A rejected request goes straight to the result register without a scan.
// After reset a clearing pass writes every row, with in_ready low.
// A request is taken only when idle; a waiting result holds back the next result only.
`timescale 1ns / 1ps
`default_nettype none
module contiguous_block_allocator_top #(
	parameter int BLOCK_COUNT = 4096,
	parameter int MAX_RUN = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [cba_pkg::HINT_W-1:0]   start_hint,
	input  wire logic [cba_pkg::LEN_W-1:0]    run_length,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              found,
	output logic      [cba_pkg::HINT_W-1:0]   first_block
);

	localparam int ROWS = BLOCK_COUNT / cba_pkg::WORD_W;
	localparam int AW = $clog2(ROWS);
	localparam int BIW = AW + cba_pkg::WORD_LG;
	localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

	cba_pkg::cba_state_t state_q;

	logic [AW-1:0]                    rd_row_q;
	logic                             rd_more_q;
	logic                             scan_v_s1;
	logic                             mark_v_s1;
	logic [AW-1:0]                    row_s1;
	logic [AW-1:0]                    clr_row_q;
	logic                             fw_q;
	logic [cba_pkg::LEN_W-1:0]        c_q;
	logic [cba_pkg::WORD_LG-1:0]      hb_q;
	logic [cba_pkg::LEN_W-1:0]        len_q;
	logic [BIW-1:0]                   run_first_q;
	logic [BIW-1:0]                   run_last_q;
	logic                             res_found_q;
	logic [cba_pkg::HINT_W-1:0]       res_first_q;
	logic                             out_valid_q;
	logic                             found_q;
	logic [cba_pkg::HINT_W-1:0]       first_q;

	logic                             ram_we;
	logic [AW-1:0]                    ram_waddr;
	logic [cba_pkg::WORD_W-1:0]       ram_wdata;
	logic [cba_pkg::WORD_W-1:0]       ram_rdata;

	logic                             in_acc;
	logic                             bad_req;
	logic                             issue_scan;
	logic                             issue_mark;
	logic                             issue;
	logic                             out_free;

	logic [cba_pkg::WORD_W-1:0]       alloc;
	logic [5:0]                       pm [6][cba_pkg::WORD_W];
	logic [cba_pkg::RUN_W-1:0]        run [cba_pkg::WORD_W];
	logic [cba_pkg::WORD_W-1:0]       hit;
	logic                             hit_any;
	logic [cba_pkg::WORD_LG-1:0]      hit_idx;
	logic [cba_pkg::LEN_W-1:0]        carry_out;
	logic [BIW-1:0]                   hit_last;
	logic [BIW-1:0]                   hit_first;

	logic [AW-1:0]                    first_row;
	logic [AW-1:0]                    last_row;
	logic [cba_pkg::WORD_LG-1:0]      mask_lo;
	logic [cba_pkg::WORD_LG-1:0]      mask_hi;
	logic [cba_pkg::WORD_W-1:0]       mark_mask;

	cba_ram #(
		.WIDTH (cba_pkg::WORD_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_row_q),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == cba_pkg::S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign bad_req = (run_length == '0) || (32'(run_length) > MAX_RUN)
		|| (32'(start_hint) >= BLOCK_COUNT);
	assign out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign first_block = first_q;

	// run search over one row: prefix of last allocated position, then run length per bit
	always_comb begin
		for (int j = 0; j < cba_pkg::WORD_W; j++) begin
			alloc[j] = ram_rdata[j] || (fw_q && (5'(j) < hb_q));
			pm[0][j] = alloc[j] ? 6'(j + 1) : 6'd0;
		end
		for (int l = 0; l < 5; l++) begin
			for (int j = 0; j < cba_pkg::WORD_W; j++) begin
				if (j >= (1 << l)) begin
					pm[l+1][j] = (pm[l][j] > pm[l][j-(1<<l)]) ? pm[l][j] : pm[l][j-(1<<l)];
				end else begin
					pm[l+1][j] = pm[l][j];
				end
			end
		end
		for (int j = 0; j < cba_pkg::WORD_W; j++) begin
			if (pm[5][j] == 6'd0) begin
				run[j] = 8'(j + 1) + {1'b0, c_q};
			end else begin
				run[j] = 8'(j + 1) - {2'b00, pm[5][j]};
			end
			hit[j] = (run[j] >= {1'b0, len_q});
		end
		hit_any = |hit;
		hit_idx = '0;
		for (int j = cba_pkg::WORD_W - 1; j >= 0; j--) begin
			if (hit[j]) begin
				hit_idx = 5'(j);
			end
		end
		carry_out = run[cba_pkg::WORD_W-1][7] ? 7'h7f : run[cba_pkg::WORD_W-1][6:0];
		hit_last = {row_s1, hit_idx};
		hit_first = hit_last + BIW'(1) - BIW'(len_q);
	end

	assign issue_scan = (state_q == cba_pkg::S_SCAN) && rd_more_q && !(scan_v_s1 && hit_any);
	assign issue_mark = (state_q == cba_pkg::S_MARK) && rd_more_q;
	assign issue = issue_scan || issue_mark;

	assign first_row = run_first_q[BIW-1:cba_pkg::WORD_LG];
	assign last_row = run_last_q[BIW-1:cba_pkg::WORD_LG];

	always_comb begin
		mask_lo = (row_s1 == first_row) ? run_first_q[cba_pkg::WORD_LG-1:0] : 5'd0;
		mask_hi = (row_s1 == last_row) ? run_last_q[cba_pkg::WORD_LG-1:0] : 5'd31;
		mark_mask = ({cba_pkg::WORD_W{1'b1}} << mask_lo)
			& ({cba_pkg::WORD_W{1'b1}} >> (5'd31 - mask_hi));
	end

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = row_s1;
		ram_wdata = ram_rdata | mark_mask;
		if (state_q == cba_pkg::S_CLEAR) begin
			ram_we = 1'b1;
			ram_waddr = clr_row_q;
			ram_wdata = '0;
		end else if ((state_q == cba_pkg::S_MARK) && mark_v_s1) begin
			ram_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::S_CLEAR;
			clr_row_q <= '0;
			rd_more_q <= 1'b0;
			scan_v_s1 <= 1'b0;
			mark_v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_v_s1 <= issue_scan;
			mark_v_s1 <= issue_mark;
			if (issue) begin
				if (rd_row_q == ((state_q == cba_pkg::S_MARK) ? last_row : LAST_ROW)) begin
					rd_more_q <= 1'b0;
				end else begin
					rd_more_q <= 1'b1;
				end
			end
			out_valid_q <= (out_valid_q && !out_ready)
				|| ((state_q == cba_pkg::S_RESP) && out_free);
			unique case (state_q)
				cba_pkg::S_CLEAR: begin
					clr_row_q <= clr_row_q + AW'(1);
					if (clr_row_q == LAST_ROW) begin
						state_q <= cba_pkg::S_IDLE;
					end
				end
				cba_pkg::S_IDLE: begin
					if (in_acc) begin
						if (bad_req) begin
							state_q <= cba_pkg::S_RESP;
						end else begin
							state_q <= cba_pkg::S_SCAN;
							rd_more_q <= 1'b1;
						end
					end
				end
				cba_pkg::S_SCAN: begin
					if (scan_v_s1) begin
						if (hit_any) begin
							state_q <= cba_pkg::S_MARK;
							rd_more_q <= 1'b1;
						end else if (row_s1 == LAST_ROW) begin
							state_q <= cba_pkg::S_RESP;
						end
					end
				end
				cba_pkg::S_MARK: begin
					if (mark_v_s1 && (row_s1 == last_row)) begin
						state_q <= cba_pkg::S_RESP;
					end
				end
				cba_pkg::S_RESP: begin
					if (out_free) begin
						state_q <= cba_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= cba_pkg::S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			row_s1 <= rd_row_q;
			rd_row_q <= rd_row_q + AW'(1);
		end
		if (scan_v_s1) begin
			fw_q <= 1'b0;
			c_q <= carry_out;
		end
		if (in_acc) begin
			rd_row_q <= AW'(start_hint >> cba_pkg::WORD_LG);
			hb_q <= start_hint[cba_pkg::WORD_LG-1:0];
			len_q <= run_length;
			fw_q <= 1'b1;
			c_q <= '0;
			res_found_q <= 1'b0;
			res_first_q <= '0;
		end
		if ((state_q == cba_pkg::S_SCAN) && scan_v_s1 && hit_any) begin
			run_first_q <= hit_first;
			run_last_q <= hit_last;
			rd_row_q <= hit_first[BIW-1:cba_pkg::WORD_LG];
			res_found_q <= 1'b1;
			res_first_q <= cba_pkg::HINT_W'(hit_first);
		end
		if ((state_q == cba_pkg::S_RESP) && out_free) begin
			found_q <= res_found_q;
			first_q <= res_first_q;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/cba_checker.sv =====
// Port-level checker for the contiguous block allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cba_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       in_valid,
	input wire logic                       in_ready,
	input wire logic [cba_pkg::HINT_W-1:0] start_hint,
	input wire logic [cba_pkg::LEN_W-1:0]  run_length,
	input wire logic                       out_valid,
	input wire logic                       out_ready,
	input wire logic                       found,
	input wire logic [cba_pkg::HINT_W-1:0] first_block
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 2'd1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 2'd1;
		end
	end

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(start_hint) && $stable(run_length))
		else $error("request changed while waiting");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(found) && $stable(first_block))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> first_block == '0)
		else $error("failed request with non-zero block");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3 && !(pend_q == 2'd2 && in_ready))
		else $error("too many requests outstanding");

endmodule

bind contiguous_block_allocator_top cba_checker u_cba_checker (.*);
`default_nettype wire
